// File: sv/etcb_pkg.sv
// ----------------------------------------------------------------------------
// etcb_pkg
// Shared types and constants of the event trace capture buffer.
// ----------------------------------------------------------------------------
package etcb_pkg;

   localparam int TRACE_DEPTH_DEFAULT = 1024;
   localparam logic [31:0] NS_PER_TICK_RESET = 32'd390095;

   localparam logic [2:0] OP_RECORD = 3'd0;
   localparam logic [2:0] OP_START  = 3'd1;
   localparam logic [2:0] OP_ARM    = 3'd2;
   localparam logic [2:0] OP_FREEZE = 3'd3;
   localparam logic [2:0] OP_READ   = 3'd4;

   typedef struct packed {
      logic [7:0]  code;
      logic [1:0]  phase;
      logic [7:0]  isr;
      logic [7:0]  thread;
      logic [31:0] stamp;
   } entry_type;

   localparam int ENTRY_W = $bits(entry_type);

   typedef struct packed {
      logic tracing;
      logic armed;
      logic wrapped;
   } status_type;

   typedef struct packed {
      logic        entry_valid;
      logic [7:0]  event_code;
      logic [1:0]  phase;
      logic [7:0]  isr_id;
      logic [7:0]  thread_id;
      logic [31:0] time_ns;
      status_type  status;
   } result_type;

endpackage

// File: sv/etcb_ram.sv
// ----------------------------------------------------------------------------
// etcb_ram
// Generic RAM: one write port, two read ports with registered read data.
// ----------------------------------------------------------------------------
module etcb_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr_a,
   input  logic [$clog2(DEPTH)-1:0] rd_addr_b,
   output logic [WIDTH-1:0]         rd_data_a,
   output logic [WIDTH-1:0]         rd_data_b
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_a_ff;
   logic [WIDTH-1:0] rd_b_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_a_ff <= mem_ff[rd_addr_a];
         rd_b_ff <= mem_ff[rd_addr_b];
      end
   end

   assign rd_data_a = rd_a_ff;
   assign rd_data_b = rd_b_ff;

endmodule

// File: sv/etcb_time_scale.sv
// ----------------------------------------------------------------------------
// etcb_time_scale
// Tick delta to nanoseconds (Q16.16 factor, saturated), result register.
// ----------------------------------------------------------------------------
module etcb_time_scale #(
   parameter int CW = 11
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   in_valid,
   output logic                   in_ready,
   input  logic                   in_hit,
   input  etcb_pkg::status_type   in_status,
   input  logic [CW-1:0]          in_count,
   input  etcb_pkg::entry_type    in_entry,
   input  logic [31:0]            in_base_stamp,
   input  logic [31:0]            in_factor,
   output logic                   out_valid,
   input  logic                   out_stall,
   output etcb_pkg::result_type   out_result,
   output logic [CW-1:0]          out_count
);
   import etcb_pkg::*;

   logic        mul_valid_ff;
   logic        mul_hit_ff;
   status_type  mul_status_ff;
   logic [CW-1:0] mul_count_ff;
   entry_type   mul_entry_ff;
   logic [63:0] mul_product_ff;
   logic [63:0] mul_product_in;

   logic        out_valid_ff;
   result_type  out_result_ff;
   result_type  out_result_in;
   logic [CW-1:0] out_count_ff;

   logic [31:0] delta;
   logic [31:0] scaled;
   logic        out_free;
   logic        mul_free;

   assign out_free = !out_valid_ff || !out_stall;
   assign mul_free = !mul_valid_ff || out_free;
   assign in_ready = mul_free;

   always_comb begin
      delta = in_entry.stamp - in_base_stamp;
      mul_product_in = 64'(delta) * 64'(in_factor);
      // product >> 16 overflows 32 bits when the top 16 bits are set
      scaled = (mul_product_ff[63:48] != 16'd0) ? 32'hFFFF_FFFF : mul_product_ff[47:16];
      out_result_in.entry_valid = mul_hit_ff;
      out_result_in.event_code  = mul_hit_ff ? mul_entry_ff.code   : 8'd0;
      out_result_in.phase       = mul_hit_ff ? mul_entry_ff.phase  : 2'd0;
      out_result_in.isr_id      = mul_hit_ff ? mul_entry_ff.isr    : 8'd0;
      out_result_in.thread_id   = mul_hit_ff ? mul_entry_ff.thread : 8'd0;
      out_result_in.time_ns     = mul_hit_ff ? scaled : 32'd0;
      out_result_in.status      = mul_status_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mul_valid_ff <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         if (mul_free) begin
            mul_valid_ff <= in_valid;
         end
         if (out_free) begin
            out_valid_ff <= mul_valid_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (mul_free && in_valid) begin
         mul_hit_ff     <= in_hit;
         mul_status_ff  <= in_status;
         mul_count_ff   <= in_count;
         mul_entry_ff   <= in_entry;
         mul_product_ff <= mul_product_in;
      end
      if (out_free && mul_valid_ff) begin
         out_result_ff <= out_result_in;
         out_count_ff  <= mul_count_ff;
      end
   end

   assign out_valid  = out_valid_ff;
   assign out_result = out_result_ff;
   assign out_count  = out_count_ff;

endmodule

// File: sv/event_trace_capture_buffer.sv
// ----------------------------------------------------------------------------
// event_trace_capture_buffer
// Trace capture store with linear and ring modes and time-ordered readout.
//
// Request channel (req_*): valid/stall. Each request carries an opcode:
// record, start linear trace, arm ring mode, freeze or read entry. Every
// request gives exactly one response on the rsp_* channel, in order.
// A read returns the entry at a time-ordered position with its time in ns
// from the oldest entry; positions past the valid count read as zeros.
// csr_* writes the Q16.16 ns-per-tick factor; csr_ready is always high.
// From request to response the pipeline registers the entry RAM read (two
// read ports: target and oldest entry), then the 32x32 multiply, then the
// response register. A request can be taken every cycle while req_stall
// is low. When the receiver stalls, the pipeline fills and req_stall rises;
// nothing is dropped. Reset clears the flags, the write index and the
// pipeline and restores the factor; the entry RAM is not cleared, and no
// clearing pass is needed since unwritten positions are never read.
// ----------------------------------------------------------------------------
module event_trace_capture_buffer #(
   parameter int TRACE_DEPTH = etcb_pkg::TRACE_DEPTH_DEFAULT
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   output logic                             req_stall,
   input  logic [2:0]                       req_opcode,
   input  logic [7:0]                       req_event_code,
   input  logic [1:0]                       req_event_phase,
   input  logic [8:0]                       req_active_vector,
   input  logic [7:0]                       req_current_thread,
   input  logic [31:0]                      req_tick_stamp,
   input  logic [9:0]                       req_read_position,
   output logic                             rsp_valid,
   input  logic                             rsp_stall,
   output logic                             rsp_entry_valid,
   output logic [7:0]                       rsp_out_event,
   output logic [1:0]                       rsp_out_phase,
   output logic [7:0]                       rsp_out_isr_id,
   output logic [7:0]                       rsp_out_thread_id,
   output logic [31:0]                      rsp_time_ns,
   output logic                             rsp_is_tracing,
   output logic                             rsp_is_armed,
   output logic                             rsp_has_wrapped,
   output logic [$clog2(TRACE_DEPTH+1)-1:0] rsp_valid_count,
   input  logic                             csr_valid,
   output logic                             csr_ready,
   input  logic [31:0]                      csr_ns_per_tick_q16
);
   import etcb_pkg::*;

   localparam int AW = $clog2(TRACE_DEPTH);
   localparam int CW = $clog2(TRACE_DEPTH + 1);
   localparam int PW = (CW > 10) ? CW : 10;
   localparam int SW = ((AW > 10) ? AW : 10) + 1;

   logic [AW-1:0] write_index_ff, write_index_in;
   logic          tracing_ff, tracing_in;
   logic          armed_ff, armed_in;
   logic          wrapped_ff, wrapped_in;
   logic          full_ff, full_in;
   logic [31:0]   factor_ff;

   logic          s1_valid_ff;
   logic          s1_hit_ff, s1_hit_in;
   status_type    s1_status_ff;
   logic [CW-1:0] s1_count_ff, s1_count_in;

   logic          accept;
   logic          scale_ready;
   logic          wr_en;
   logic          rd_en;
   entry_type     wr_entry;
   logic [CW-1:0] held;
   logic [AW-1:0] oldest;
   logic [SW-1:0] pos_sum;
   logic [AW-1:0] phys;
   logic [ENTRY_W-1:0] rd_target;
   logic [ENTRY_W-1:0] rd_oldest;
   entry_type     target_entry;
   entry_type     oldest_entry;
   result_type    result;

   assign req_stall = s1_valid_ff && !scale_ready;
   assign accept    = req_valid && !req_stall;
   assign csr_ready = 1'b1;

   always_comb begin
      held   = (wrapped_ff || full_ff) ? CW'(TRACE_DEPTH) : CW'(write_index_ff);
      oldest = wrapped_ff ? write_index_ff : '0;
      pos_sum = SW'(oldest) + SW'(req_read_position);
      if (pos_sum >= SW'(TRACE_DEPTH)) begin
         pos_sum = pos_sum - SW'(TRACE_DEPTH);
      end
      phys = pos_sum[AW-1:0];

      wr_entry.code   = req_event_code;
      wr_entry.phase  = req_event_phase;
      wr_entry.isr    = (req_active_vector == 9'd0) ? 8'd0 : (req_active_vector[7:0] - 8'd16);
      wr_entry.thread = (req_active_vector == 9'd0) ? req_current_thread : 8'd0;
      wr_entry.stamp  = req_tick_stamp;

      write_index_in = write_index_ff;
      tracing_in     = tracing_ff;
      armed_in       = armed_ff;
      wrapped_in     = wrapped_ff;
      full_in        = full_ff;
      wr_en          = 1'b0;
      rd_en          = 1'b0;
      s1_hit_in      = 1'b0;

      if (accept) begin
         unique case (req_opcode)
            OP_RECORD: begin
               if (tracing_ff) begin
                  wr_en = 1'b1;
                  if (write_index_ff == AW'(TRACE_DEPTH - 1)) begin
                     write_index_in = '0;
                     if (armed_ff) begin
                        wrapped_in = 1'b1;
                     end else begin
                        full_in    = 1'b1;
                        tracing_in = 1'b0;
                     end
                  end else begin
                     write_index_in = write_index_ff + AW'(1);
                  end
               end
            end
            OP_START, OP_ARM: begin
               write_index_in = '0;
               wrapped_in     = 1'b0;
               full_in        = 1'b0;
               armed_in       = (req_opcode == OP_ARM);
               tracing_in     = 1'b1;
            end
            OP_FREEZE: begin
               if (tracing_ff && armed_ff) begin
                  tracing_in = 1'b0;
                  armed_in   = 1'b0;
               end
            end
            OP_READ: begin
               rd_en      = 1'b1;
               tracing_in = 1'b0;
               armed_in   = 1'b0;
               s1_hit_in  = PW'(req_read_position) < PW'(held);
            end
            default: begin
               // undefined opcodes leave the state alone
            end
         endcase
      end

      s1_count_in = (wrapped_in || full_in) ? CW'(TRACE_DEPTH) : CW'(write_index_in);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         write_index_ff <= '0;
         tracing_ff     <= 1'b0;
         armed_ff       <= 1'b0;
         wrapped_ff     <= 1'b0;
         full_ff        <= 1'b0;
         factor_ff      <= NS_PER_TICK_RESET;
         s1_valid_ff    <= 1'b0;
      end else begin
         write_index_ff <= write_index_in;
         tracing_ff     <= tracing_in;
         armed_ff       <= armed_in;
         wrapped_ff     <= wrapped_in;
         full_ff        <= full_in;
         if (csr_valid && csr_ready) begin
            factor_ff <= csr_ns_per_tick_q16;
         end
         if (accept) begin
            s1_valid_ff <= 1'b1;
         end else if (scale_ready) begin
            s1_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_hit_ff    <= s1_hit_in;
         s1_status_ff <= '{tracing: tracing_in, armed: armed_in, wrapped: wrapped_in};
         s1_count_ff  <= s1_count_in;
      end
   end

   etcb_ram #(
      .WIDTH (ENTRY_W),
      .DEPTH (TRACE_DEPTH)
   ) u_store (
      .clock     (clock),
      .wr_en     (wr_en),
      .wr_addr   (write_index_ff),
      .wr_data   (wr_entry),
      .rd_en     (rd_en),
      .rd_addr_a (phys),
      .rd_addr_b (oldest),
      .rd_data_a (rd_target),
      .rd_data_b (rd_oldest)
   );

   assign target_entry = entry_type'(rd_target);
   assign oldest_entry = entry_type'(rd_oldest);

   etcb_time_scale #(
      .CW (CW)
   ) u_scale (
      .clock         (clock),
      .reset         (reset),
      .in_valid      (s1_valid_ff),
      .in_ready      (scale_ready),
      .in_hit        (s1_hit_ff),
      .in_status     (s1_status_ff),
      .in_count      (s1_count_ff),
      .in_entry      (target_entry),
      .in_base_stamp (oldest_entry.stamp),
      .in_factor     (factor_ff),
      .out_valid     (rsp_valid),
      .out_stall     (rsp_stall),
      .out_result    (result),
      .out_count     (rsp_valid_count)
   );

   assign rsp_entry_valid   = result.entry_valid;
   assign rsp_out_event     = result.event_code;
   assign rsp_out_phase     = result.phase;
   assign rsp_out_isr_id    = result.isr_id;
   assign rsp_out_thread_id = result.thread_id;
   assign rsp_time_ns       = result.time_ns;
   assign rsp_is_tracing    = result.status.tracing;
   assign rsp_is_armed      = result.status.armed;
   assign rsp_has_wrapped   = result.status.wrapped;

endmodule
